/* hdl/bed4_pkg.sv */
// ----------------------------------------------------------------------------
// bed4_pkg
// shared widths, register indexes and types for the 4-d distance block
// ----------------------------------------------------------------------------
package bed4_pkg;

    // field widths on the ports
    localparam int COORD_W            = 24;
    localparam int DEFAULT_COORD_BITS = 24;
    localparam int NUM_LANES          = 4;
    localparam int SQ_W               = 50;
    localparam int RES_W              = 25;
    localparam int S_TDATA_W          = NUM_LANES * COORD_W;
    localparam int M_TDATA_W          = ((SQ_W + RES_W + 7) / 8) * 8;
    localparam int M_PAD_W            = M_TDATA_W - SQ_W - RES_W;
    localparam int CFG_IDX_W          = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_X = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_Y = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_Z = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_M = 4'd3;

    // lane order inside a point word
    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_Z = 2;
    localparam int LANE_M = 3;

    // four coordinates, x in the lowest bits
    typedef logic [NUM_LANES-1:0][COORD_W-1:0] coord4_t;

endpackage

/* hdl/bed4_cfg.sv */
// ----------------------------------------------------------------------------
// bed4_cfg
// query point register file, written over the configuration channel
// ----------------------------------------------------------------------------
module bed4_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bed4_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bed4_pkg::COORD_W-1:0]   cfg_data,
    output bed4_pkg::coord4_t              query
);
    import bed4_pkg::*;

    coord4_t query_reg;

    assign cfg_ready = 1'b1;
    assign query     = query_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_QUERY_X: query_reg[LANE_X] <= cfg_data;
                REG_QUERY_Y: query_reg[LANE_Y] <= cfg_data;
                REG_QUERY_Z: query_reg[LANE_Z] <= cfg_data;
                REG_QUERY_M: query_reg[LANE_M] <= cfg_data;
                // unknown index: write dropped
                default: ;
            endcase
        end
    end

endmodule

/* hdl/bed4_sqdist.sv */
// ----------------------------------------------------------------------------
// bed4_sqdist
// four-stage pipeline: subtract, square, pair sums, total squared distance
// ----------------------------------------------------------------------------
module bed4_sqdist #(
    parameter int COORD_BITS = bed4_pkg::DEFAULT_COORD_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  bed4_pkg::coord4_t         query,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  bed4_pkg::coord4_t         in_point,
    input  logic                      in_last,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [2*COORD_BITS+1:0]   out_sq,
    output logic                      out_last
);
    import bed4_pkg::*;

    localparam int DW = COORD_BITS + 1;     // signed difference
    localparam int PW = 2 * COORD_BITS;     // one square
    localparam int SW = 2 * COORD_BITS + 2; // sum of four squares

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic r1, r2, r3, r4;

    logic signed [DW-1:0]   diff_reg [NUM_LANES];
    logic signed [DW-1:0]   diff_next [NUM_LANES];
    logic signed [2*DW-1:0] prod_next [NUM_LANES];
    logic [PW-1:0]          sq_reg [NUM_LANES];
    logic [PW:0]            pair0_reg, pair1_reg;
    logic [SW-1:0]          total_reg;
    logic                   last1_reg, last2_reg, last3_reg, last4_reg;

    // per-stage ready, bubbles collapse
    assign r4       = !v4_reg || out_ready;
    assign r3       = !v3_reg || r4;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            diff_next[i] = {query[i][COORD_BITS-1], query[i][COORD_BITS-1:0]}
                         - {in_point[i][COORD_BITS-1], in_point[i][COORD_BITS-1:0]};
            prod_next[i] = diff_reg[i] * diff_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (r1) v1_reg <= in_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && r1)
        begin
            for (int i = 0; i < NUM_LANES; i++)
            begin
                diff_reg[i] <= diff_next[i];
            end
            last1_reg <= in_last;
        end
        if (v1_reg && r2)
        begin
            // square of a difference is below 2^(2*COORD_BITS)
            for (int i = 0; i < NUM_LANES; i++)
            begin
                sq_reg[i] <= prod_next[i][PW-1:0];
            end
            last2_reg <= last1_reg;
        end
        if (v2_reg && r3)
        begin
            pair0_reg <= {1'b0, sq_reg[0]} + {1'b0, sq_reg[1]};
            pair1_reg <= {1'b0, sq_reg[2]} + {1'b0, sq_reg[3]};
            last3_reg <= last2_reg;
        end
        if (v3_reg && r4)
        begin
            total_reg <= {1'b0, pair0_reg} + {1'b0, pair1_reg};
            last4_reg <= last3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_sq    = total_reg;
    assign out_last  = last4_reg;

endmodule

/* hdl/bed4_sqrt.sv */
// ----------------------------------------------------------------------------
// bed4_sqrt
// pipelined restoring square root, one result bit per stage, msb first
// ----------------------------------------------------------------------------
module bed4_sqrt #(
    parameter int COORD_BITS = bed4_pkg::DEFAULT_COORD_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [2*COORD_BITS+1:0]   in_sq,
    input  logic                      in_last,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [2*COORD_BITS+1:0]   out_sq,
    output logic [COORD_BITS:0]       out_root,
    output logic                      out_last
);
    localparam int RB = COORD_BITS + 1;
    localparam int SW = 2 * RB;

    logic          valid_q [RB];
    logic          ready_q [RB];
    logic [RB-1:0] root_q  [RB];
    logic [SW-1:0] rem_q   [RB-1];
    logic [SW-1:0] sq_q    [RB];
    logic          last_q  [RB];

    for (genvar k = 0; k < RB; k++)
    begin : g_stage
        localparam int B = RB - 1 - k;

        logic          valid_prev;
        logic [RB-1:0] root_prev;
        logic [SW-1:0] rem_prev;
        logic [SW-1:0] sq_prev;
        logic          last_prev;
        logic          ready_next;
        logic [SW:0]   trial;
        logic [SW:0]   diff;
        logic          take;
        logic [RB-1:0] root_next;
        logic          valid_reg;
        logic [RB-1:0] root_reg;
        logic [SW-1:0] sq_reg;
        logic          last_reg;

        if (k == 0)
        begin : g_first
            assign valid_prev = in_valid;
            assign root_prev  = '0;
            assign rem_prev   = in_sq;
            assign sq_prev    = in_sq;
            assign last_prev  = in_last;
        end
        else
        begin : g_next
            assign valid_prev = valid_q[k-1];
            assign root_prev  = root_q[k-1];
            assign rem_prev   = rem_q[k-1];
            assign sq_prev    = sq_q[k-1];
            assign last_prev  = last_q[k-1];
        end

        if (k == RB - 1)
        begin : g_tail
            assign ready_next = out_ready;
        end
        else
        begin : g_body
            assign ready_next = ready_q[k+1];
        end

        // (root + 2^B)^2 - root^2 = root*2^(B+1) + 2^(2B), root has no bits below B+1
        assign trial     = ((SW+1)'(root_prev) << (B + 1)) | ((SW+1)'(1) << (2 * B));
        assign diff      = {1'b0, rem_prev} - trial;
        assign take      = !diff[SW];
        assign root_next = take ? (root_prev | (RB'(1) << B)) : root_prev;

        assign ready_q[k] = !valid_reg || ready_next;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (ready_q[k])
            begin
                valid_reg <= valid_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (valid_prev && ready_q[k])
            begin
                root_reg <= root_next;
                sq_reg   <= sq_prev;
                last_reg <= last_prev;
            end
        end

        // remainder is not needed past the last bit
        if (k < RB - 1)
        begin : g_rem
            logic [SW-1:0] rem_reg;

            always_ff @(posedge clk)
            begin
                if (valid_prev && ready_q[k])
                begin
                    rem_reg <= take ? diff[SW-1:0] : rem_prev;
                end
            end

            assign rem_q[k] = rem_reg;
        end

        assign valid_q[k] = valid_reg;
        assign root_q[k]  = root_reg;
        assign sq_q[k]    = sq_reg;
        assign last_q[k]  = last_reg;
    end

    assign in_ready  = ready_q[0];
    assign out_valid = valid_q[RB-1];
    assign out_root  = root_q[RB-1];
    assign out_sq    = sq_q[RB-1];
    assign out_last  = last_q[RB-1];

endmodule

/* hdl/batch_euclidean_distance_4d.sv */
// ----------------------------------------------------------------------------
// batch_euclidean_distance_4d
// squared distance and floor square root from each point to a query point
// ----------------------------------------------------------------------------
//  channel   dir  handshake               payload
//  s_axis    in   s_axis_tvalid/tready    tdata: point x,y,z,m; tlast: batch_end
//  m_axis    out  m_axis_tvalid/tready    tdata: dist_squared, dist_res; tlast
//  cfg       in   cfg_valid/cfg_ready     cfg_index, cfg_data (query x,y,z,m)
//
//  one point per cycle sustained while m_axis accepts; the difference, square
//  and sum stages come first, then the root stages, msb first.
//  every stage holds its own valid bit and loads when the next one has room,
//  so a stall on m_axis fills bubbles before s_axis_tready drops.
//  reset clears the valid bits and the query point; cfg_ready is always high.
// ----------------------------------------------------------------------------
module batch_euclidean_distance_4d #(
    parameter int COORD_BITS = bed4_pkg::DEFAULT_COORD_BITS
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [bed4_pkg::S_TDATA_W-1:0] s_axis_tdata,  // point_x, point_y, point_z, point_m
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [bed4_pkg::M_TDATA_W-1:0] m_axis_tdata,  // dist_squared, dist_res, zero pad
    output logic                           m_axis_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bed4_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bed4_pkg::COORD_W-1:0]   cfg_data
);
    import bed4_pkg::*;

    localparam int RB = COORD_BITS + 1;
    localparam int SW = 2 * RB;

    coord4_t       query;
    coord4_t       point;
    logic          mid_valid;
    logic          mid_ready;
    logic [SW-1:0] mid_sq;
    logic          mid_last;
    logic [SW-1:0] res_sq;
    logic [RB-1:0] res_root;

    assign point = coord4_t'(s_axis_tdata);

    bed4_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .query     (query)
    );

    bed4_sqdist #(
        .COORD_BITS (COORD_BITS)
    ) u_sqdist
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .query     (query),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_point  (point),
        .in_last   (s_axis_tlast),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_sq    (mid_sq),
        .out_last  (mid_last)
    );

    bed4_sqrt #(
        .COORD_BITS (COORD_BITS)
    ) u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_sq     (mid_sq),
        .in_last   (mid_last),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_sq    (res_sq),
        .out_root  (res_root),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {{M_PAD_W{1'b0}}, RES_W'(res_root), SQ_W'(res_sq)};

    // root bracket for the check below
    logic [2*RES_W+1:0] chk_lo;
    logic [2*RES_W+1:0] chk_hi;
    logic [RES_W:0]     chk_root;

    assign chk_root = {1'b0, m_axis_tdata[SQ_W +: RES_W]};
    assign chk_lo   = chk_root * chk_root;
    assign chk_hi   = (chk_root + 1'b1) * (chk_root + 1'b1);

    // root on the output word is the floor square root of the sum beside it
    a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (chk_lo <= (2*RES_W+2)'(m_axis_tdata[SQ_W-1:0]))
                       && (chk_hi >  (2*RES_W+2)'(m_axis_tdata[SQ_W-1:0])))
        else $error("dist_res is not the floor root of dist_squared");

    // the pipeline can only block input when a result waits at the output
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with output stage empty");

    // a word waiting at the output must still be there in the next cycle
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("stalled output word dropped");

endmodule
